// ===== rtl/array_list_engine_defines.svh =====
// Assertion macros for the list engine.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ale_pkg.sv =====
`default_nettype none

package ale_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int POS_W            = 10;
  localparam int WORD_W           = 32;
  localparam int LEN_W            = 11;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_FIRST,
    S_REM_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]               command;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [LEN_W-1:0]         list_length;
    logic [1:0]               status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/array_list_engine.sv =====
// Ordered list of signed 32-bit words in a single-port-write, registered-read
// memory of CAPACITY entries, with a length count.
// Request channel (req_valid, req_stall, req): one command per beat; read,
// write, append, insert or remove. Response channel (rsp_valid, rsp_stall,
// rsp): exactly one beat per command with the word read or removed, the
// length after the command and a status (ok, index out of range, full).
// A read passes through the decide, read and done steps; write, append and
// rejected commands through decide and done only; insert and remove walk
// the list between decide and done. Insert and remove move one element per
// cycle through the single memory port, so their time grows with the number
// of elements at or above the position. req_stall is high while a command
// is in progress; one command is worked on at a time.
// The response sits in an output register; a new command is taken while it
// waits, and a finished command holds in its last step while rsp_stall is
// high and the register is full.
// Reset empties the list and drops any pending response. Memory contents are
// not cleared; only entries below the length are ever read.
`default_nettype none

module array_list_engine #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ale_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ale_pkg::rsp_t      rsp
);
  import ale_pkg::*;

  `include "array_list_engine_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [0:CAPACITY-1];
  logic [WORD_W-1:0] rd_data;

  state_e            state, state_next;
  logic [2:0]        cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     w, w_next;
  logic [WORD_W-1:0] res_word, res_word_next;
  status_e           res_status, res_status_next;

  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic [AW-1:0]     ra;
  logic              rsp_load;

  logic              in_range;
  logic              full;
  logic [AW-1:0]     pos_a;
  logic [AW-1:0]     count_a;
  logic [CW-1:0]     w_c;

  assign in_range = WW'(pos_r) < WW'(count);
  assign full     = count == CW'(CAPACITY);
  assign pos_a    = AW'(pos_r);
  assign count_a  = AW'(count);
  assign w_c      = CW'(w);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cmd_r  <= req.command;
      pos_r  <= req.position;
      word_r <= req.word_in;
    end
    w          <= w_next;
    res_word   <= res_word_next;
    res_status <= res_status_next;
    if (rsp_load) begin
      rsp.word_out    <= res_word;
      rsp.list_length <= LEN_W'(count);
      rsp.status      <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    w_next          = w;
    res_word_next   = res_word;
    res_status_next = res_status;
    we              = 1'b0;
    wa              = '0;
    wd              = word_r;
    ra              = '0;
    req_stall       = 1'b1;
    rsp_load        = 1'b0;

    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_word_next   = '0;
        res_status_next = ST_OK;
        state_next      = S_DONE;
        case (cmd_r)
          CMD_READ: begin
            if (in_range) begin
              ra         = pos_a;
              state_next = S_READ;
            end else begin
              res_status_next = ST_RANGE;
            end
          end
          CMD_WRITE: begin
            if (in_range) begin
              we = 1'b1;
              wa = pos_a;
            end else begin
              res_status_next = ST_RANGE;
            end
          end
          CMD_APPEND: begin
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              we         = 1'b1;
              wa         = count_a;
              count_next = count + CW'(1);
            end
          end
          CMD_INSERT: begin
            if (!in_range) begin
              res_status_next = ST_RANGE;
            end else if (full) begin
              res_status_next = ST_FULL;
            end else begin
              // prefetch the last element; the shift walks down from the end
              ra         = count_a - AW'(1);
              w_next     = count_a;
              state_next = S_INS_SHIFT;
            end
          end
          CMD_REMOVE: begin
            if (!in_range) begin
              res_status_next = ST_RANGE;
            end else begin
              ra         = pos_a;
              w_next     = pos_a;
              state_next = S_REM_FIRST;
            end
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        res_word_next = rd_data;
        state_next    = S_DONE;
      end

      S_INS_SHIFT: begin
        // rd_data holds element w-1; move it up and fetch the one below
        we     = 1'b1;
        wa     = w;
        wd     = rd_data;
        w_next = w - AW'(1);
        if (w - AW'(1) == pos_a) begin
          state_next = S_INS_PUT;
        end else begin
          ra = w - AW'(2);
        end
      end

      S_INS_PUT: begin
        we         = 1'b1;
        wa         = pos_a;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end

      S_REM_FIRST: begin
        res_word_next = rd_data;
        if (w_c + CW'(1) < count) begin
          ra         = w + AW'(1);
          state_next = S_REM_SHIFT;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_REM_SHIFT: begin
        // rd_data holds element w+1; move it down and fetch the next
        we     = 1'b1;
        wa     = w;
        wd     = rd_data;
        w_next = w + AW'(1);
        if (w_c + CW'(2) < count) begin
          ra = w + AW'(2);
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ALE_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "length beyond capacity")
  `ALE_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, state != S_IDLE, "idle after request")
  `ALE_ASSERT_NEXT(a_count_step, 1'b1, (count == $past(count)) || (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)), "length jumped")
  `ALE_ASSERT_NOW(a_full_len, rsp_valid && (rsp.status == ST_FULL), rsp.list_length == LEN_W'(CAPACITY), "full reported below capacity")

endmodule

`default_nettype wire

// ===== sim/tb_array_list_engine.sv =====
`timescale 1ns / 100ps

module tb_array_list_engine;
  import ale_pkg::*;

  localparam int SLOTS        = CAPACITY_DEFAULT;
  localparam int RANDOM_BEATS = 558;
  localparam int DRAIN_CYCLES = SLOTS + 16;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_beat  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_beat;

  array_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_beat)
  );

  always #2 clk = ~clk;

  // Shadow copy of the list contents and length
  logic [WORD_W-1:0] list_words [SLOTS];
  logic [LEN_W-1:0]  list_len = '0;
  rsp_t              awaited_replies [$];

  int burst_left   = 0;
  int errors       = 0;
  int replies_seen = 0;
  int range_hits   = 0;
  int full_hits    = 0;
  int longest      = 0;
  int op_count [5] = '{default: 0};

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t o;
    logic in_range;
    int   i;
    o = '0;
    in_range = (r.position < list_len);
    case (r.command)
      CMD_READ: begin
        if (in_range) o.word_out = list_words[r.position];
        else o.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (in_range) list_words[r.position] = r.word_in;
        else o.status = ST_RANGE;
      end
      CMD_APPEND: begin
        if (list_len >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          list_words[list_len] = r.word_in;
          list_len++;
        end
      end
      CMD_INSERT: begin
        // range test comes before the full test
        if (!in_range) begin
          o.status = ST_RANGE;
        end else if (list_len >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          for (i = int'(list_len); i > int'(r.position); i--) list_words[i] = list_words[i - 1];
          list_words[r.position] = r.word_in;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          o.status = ST_RANGE;
        end else begin
          o.word_out = list_words[r.position];
          for (i = int'(r.position); i + 1 < int'(list_len); i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      default: ;
    endcase
    o.list_length = list_len;
    return o;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Drive one command beat; the sender works in bursts with idle gaps between them.
  task automatic send_cmd(input cmd_e c, input int unsigned p, input logic [31:0] w);
    req_t item;
    rsp_t want;
    item.command  = c;
    item.position = p[POS_W-1:0];
    item.word_in  = w;
    @(negedge clk);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_beat  <= item;
    do @(posedge clk); while (req_stall);
    want = apply_list_op(item);
    awaited_replies.push_back(want);
    op_count[int'(c)]++;
    if (want.status == ST_RANGE) range_hits++;
    if (want.status == ST_FULL) full_hits++;
    if (int'(list_len) > longest) longest = int'(list_len);
  endtask

  // Receiver: free stretches of random length, then a short stall.
  int free_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      rsp_stall <= 1'b0;
    end else begin
      free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      hold_left = $urandom_range(1, 5);
      rsp_stall <= 1'b0;
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t reply %0d: %s expected %h, got %h", $time, replies_seen, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : reply_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t unexpected reply beat %h", $time, rsp_beat);
      end else begin
        want = awaited_replies.pop_front();
        check_field("word_out", want.word_out, rsp_beat.word_out);
        check_field("list_length", 32'(want.list_length), 32'(rsp_beat.list_length));
        check_field("status", 32'(want.status), 32'(rsp_beat.status));
      end
      replies_seen++;
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_READ, 0, 32'h0);
    send_cmd(CMD_REMOVE, 0, 32'h0);
    send_cmd(CMD_WRITE, 0, 32'h1111_1111);
    // insert at the end is out of range, even on an empty list
    send_cmd(CMD_INSERT, 0, 32'h2222_2222);
    send_cmd(CMD_READ, SLOTS - 1, 32'h0);
  endtask

  task automatic test_small_list();
    send_cmd(CMD_APPEND, 0, 32'h8000_0000);
    send_cmd(CMD_APPEND, SLOTS - 1, 32'h7FFF_FFFF);
    send_cmd(CMD_APPEND, 0, 32'h0000_0000);
    send_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 0, 32'h0);
    send_cmd(CMD_READ, 3, 32'h0);
    send_cmd(CMD_WRITE, 1, 32'h5555_5555);
    send_cmd(CMD_READ, 1, 32'h0);
    send_cmd(CMD_INSERT, 0, 32'hAAAA_AAAA);
    send_cmd(CMD_INSERT, 2, 32'h1234_5678);
    send_cmd(CMD_INSERT, 6, 32'h3333_3333);
    send_cmd(CMD_READ, 6, 32'h0);
    send_cmd(CMD_WRITE, SLOTS - 1, 32'h4444_4444);
    send_cmd(CMD_REMOVE, 5, 32'h0);
    send_cmd(CMD_REMOVE, 0, 32'h0);
    send_cmd(CMD_REMOVE, 2, 32'h0);
    send_cmd(CMD_READ, 2, 32'h0);
  endtask

  // Mostly in-range commands on short lists, with a few longer stretches.
  task automatic test_random_traffic();
    int   n;
    int   goal;
    int   roll;
    int   p;
    cmd_e c;
    goal = 8;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0)
        goal = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        c = CMD_READ;
      end else if (roll < 35) begin
        c = CMD_WRITE;
      end else if (roll < 70) begin
        if (list_len < goal) c = ($urandom_range(0, 1) != 0) ? CMD_APPEND : CMD_INSERT;
        else c = CMD_REMOVE;
      end else begin
        c = cmd_e'($urandom_range(0, 4));
      end
      roll = $urandom_range(0, 99);
      if (list_len != 0 && roll < 75) p = $urandom_range(0, int'(list_len) - 1);
      else if (roll < 88) p = int'(list_len);
      else p = $urandom_range(0, SLOTS - 1);
      send_cmd(c, p, pick_word());
    end
  endtask

  task automatic finish_traffic();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_small_list();
    test_random_traffic();
    finish_traffic();
    $display("Sent %0d read, %0d write, %0d append, %0d insert, %0d remove commands",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
    $display("Checked %0d replies: %0d out of range, %0d list full, longest list %0d",
             replies_seen, range_hits, full_hits, longest);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d replies outstanding", awaited_replies.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ale_pkg.sv
rtl/array_list_engine.sv
sim/tb_array_list_engine.sv
